### src/bia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_pkg: shared definitions for the bitmap ID allocator
// Pool geometry, field widths, operation and status codes, and the
// command, status and result structures passed between the blocks.
// ----------------------------------------------------------------------------
package bia_pkg;

	// Pool geometry. The pool size is a multiple of the map word width.
	localparam int POOL_BITS = 4096;
	localparam int WORD_BITS = 32;
	localparam int WORDS     = POOL_BITS / WORD_BITS;
	localparam int POS_W     = $clog2(POOL_BITS);
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int WADDR_W   = POS_W - BIT_W;
	localparam int STEP_W    = $clog2(WORDS + 1);

	// Field widths.
	localparam int BASE_W = 28;
	localparam int NUM_W  = 29;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;

	// Configuration port.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(1);

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd2;

	// Commands from the controller.
	typedef struct packed {
		logic idle;      // ready for a new request word
		logic load;      // capture the request word
		logic seek;      // point at the first map word to read
		logic rd;        // read the current map word
		logic adv;       // step to the next map word
		logic wr_alloc;  // mark the found bit busy
		logic wr_free;   // clear the bit being freed
		logic load_out;  // move the result into the output register
	} ctrl_cmd_t;

	// Status back to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            outside;   // freed number lies outside the pool
		logic            hit;       // current word holds a usable free bit
		logic            last_step; // current word is the final scan step
	} dp_stat_t;

	// Result word.
	typedef struct packed {
		logic [NUM_W-1:0]  result_number;
		logic              is_valid;
		logic [STAT_W-1:0] status;
	} rsp_t;

endpackage

### src/bia_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_if: request and response channels of the bitmap ID allocator
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bia_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [28:0] number;

	modport source (output valid, output operation, output number, input ready);
	modport sink   (input valid, input operation, input number, output ready);
endinterface

interface bia_rsp_if;
	logic        valid;
	logic        ready;
	logic [28:0] result_number;
	logic        is_valid;
	logic [1:0]  status;

	modport source (output valid, output result_number, output is_valid, output status,
		input ready);
	modport sink   (input valid, input result_number, input is_valid, input status,
		output ready);
endinterface

### src/bia_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_ctrl: sequencing state machine
// Decodes a request, walks the map one word per read/evaluate pair and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module bia_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               out_free,
	input  bia_pkg::dp_stat_t  stat,
	output bia_pkg::ctrl_cmd_t cmd
);
	import bia_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_EVAL,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.op == OP_ALLOC) begin
					cmd.seek = 1'b1;
					state_d  = S_READ;
				end else if (stat.op == OP_FREE && !stat.outside) begin
					cmd.seek = 1'b1;
					state_d  = S_READ;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (stat.op == OP_FREE) begin
					cmd.wr_free = 1'b1;
					state_d     = S_FINISH;
				end else if (stat.hit) begin
					cmd.wr_alloc = 1'b1;
					state_d      = S_FINISH;
				end else if (stat.last_step) begin
					state_d = S_FINISH;
				end else begin
					cmd.adv = 1'b1;
					state_d = S_READ;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/bia_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_dpath: busy map, scan pointer and result datapath
// Holds the busy map as a word memory with per-word valid flags, finds the
// lowest usable free bit in the word just read, and forms the result.
// ----------------------------------------------------------------------------
module bia_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bia_pkg::ctrl_cmd_t         cmd,
	input  logic [bia_pkg::OP_W-1:0]   op_in,
	input  logic [bia_pkg::NUM_W-1:0]  num_in,
	input  logic [bia_pkg::BASE_W-1:0] base,
	output bia_pkg::dp_stat_t          stat,
	output bia_pkg::rsp_t              result
);
	import bia_pkg::*;

	// Map storage; a word whose valid flag is clear reads as all free.
	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORDS-1:0]     wvalid_q;

	logic [OP_W-1:0]      op_q;
	logic [NUM_W-1:0]     num_q;
	logic [POS_W-1:0]     scan_pos_q;
	logic [WADDR_W-1:0]   cur_word_q;
	logic [STEP_W-1:0]    step_q;
	logic [WORD_BITS-1:0] rd_data_q;
	logic                 rd_valid_q;
	logic                 found_q;
	logic [NUM_W-1:0]     res_q;

	logic [NUM_W-1:0]     base_eff;
	logic [NUM_W-1:0]     diff;
	logic                 below_base;
	logic                 outside;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] scan_mask;
	logic [WORD_BITS-1:0] cand;
	logic                 hit;
	logic [BIT_W-1:0]     hit_idx;
	logic                 last_step;
	logic [WORD_BITS-1:0] wr_data;

	// Effective base and the free range check.
	assign base_eff   = (base == '0) ? NUM_W'(1) : NUM_W'(base);
	assign below_base = num_q < base_eff;
	assign diff       = num_q - base_eff;
	assign outside    = below_base || (diff >= NUM_W'(POOL_BITS));

	// Masked free bits of the word just read. The first step looks at bits
	// from the scan position up, the wrap-around step at the bits below it.
	assign rd_word   = rd_valid_q ? rd_data_q : '0;
	assign lo_mask   = {WORD_BITS{1'b1}} << scan_pos_q[BIT_W-1:0];
	assign last_step = step_q == STEP_W'(WORDS);
	always_comb begin
		if (step_q == '0) begin
			scan_mask = lo_mask;
		end else if (last_step) begin
			scan_mask = ~lo_mask;
		end else begin
			scan_mask = '1;
		end
	end
	assign cand = ~rd_word & scan_mask;
	assign hit  = |cand;

	// Lowest set candidate bit.
	always_comb begin
		hit_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				hit_idx = BIT_W'(i);
			end
		end
	end

	// Updated map word for allocate or free.
	always_comb begin
		if (cmd.wr_alloc) begin
			wr_data = rd_word | (WORD_BITS'(1) << hit_idx);
		end else begin
			wr_data = rd_word & ~(WORD_BITS'(1) << diff[BIT_W-1:0]);
		end
	end

	// Map memory: registered read, single write port.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_data_q <= mem[cur_word_q];
		end
		if (cmd.wr_alloc || cmd.wr_free) begin
			mem[cur_word_q] <= wr_data;
		end
	end

	// Word valid flags and the read-side copy of the flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q   <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.rd) begin
				rd_valid_q <= wvalid_q[cur_word_q];
			end
			if (cmd.wr_alloc || cmd.wr_free) begin
				wvalid_q[cur_word_q] <= 1'b1;
			end
		end
	end

	// Scan pointer and allocation result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_pos_q <= '0;
			found_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				found_q <= 1'b0;
			end
			if (cmd.wr_alloc) begin
				scan_pos_q <= {cur_word_q, hit_idx};
				found_q    <= 1'b1;
			end
		end
	end

	// Request capture, word walk and allocated number.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_in;
			num_q <= num_in;
		end
		if (cmd.seek) begin
			step_q <= '0;
			if (op_q == OP_ALLOC) begin
				cur_word_q <= scan_pos_q[POS_W-1:BIT_W];
			end else begin
				cur_word_q <= diff[POS_W-1:BIT_W];
			end
		end else if (cmd.adv) begin
			step_q <= step_q + STEP_W'(1);
			if (cur_word_q == WADDR_W'(WORDS - 1)) begin
				cur_word_q <= '0;
			end else begin
				cur_word_q <= cur_word_q + WADDR_W'(1);
			end
		end
		if (cmd.wr_alloc) begin
			res_q <= base_eff + NUM_W'({cur_word_q, hit_idx});
		end
	end

	// Status to the controller.
	assign stat.op        = op_q;
	assign stat.outside   = outside;
	assign stat.hit       = hit;
	assign stat.last_step = last_step;

	// Result fields for the finished request.
	always_comb begin
		result = '0;
		if (op_q == OP_ALLOC) begin
			result.result_number = found_q ? res_q : '0;
			result.status        = found_q ? ST_OK : ST_FULL;
		end else if (op_q == OP_FREE) begin
			result.status = outside ? ST_OUTSIDE : ST_OK;
		end else if (op_q == OP_CHECK) begin
			result.is_valid = !below_base;
		end
	end

endmodule

### src/bitmap_id_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator: next-fit number allocator over a busy bitmap
// Allocates, frees and checks numbers against a 4096-entry busy map with a
// configurable base, using a word-at-a-time next-fit scan.
//
//   Channel | Dir | Handshake        | Word
//   req     | in  | valid/ready      | operation, number
//   rsp     | out | valid/ready      | result_number, is_valid, status
//   cfg     | in  | APB write/read   | reserve_base at address 0
//
// A check or an out-of-pool free goes from decode straight to finish. A free
// passes through one read and one evaluate state. An allocate reads from 1 to
// 129 32-bit map words, each through a read state and an evaluate state.
// Reset clears the map at once through per-word valid flags, so requests are
// taken with no clearing pass after reset. A new request is accepted while
// the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module bitmap_id_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	bia_req_if.sink                        req,
	bia_rsp_if.source                      rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bia_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [bia_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [bia_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);
	import bia_pkg::*;

	ctrl_cmd_t         cmd;
	dp_stat_t          stat;
	rsp_t              result;
	rsp_t              rsp_q;
	logic              rsp_valid_q;
	logic              out_free;
	logic [BASE_W-1:0] reserve_base_q;
	logic              cfg_sel;

	// Configuration register; addresses past the register are ignored.
	assign pready  = 1'b1;
	assign cfg_sel = paddr[CFG_ADDR_W-1:2] == '0;
	assign prdata  = cfg_sel ? CFG_DATA_W'(reserve_base_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserve_base_q <= BASE_RESET;
		end else if (psel && penable && pwrite && cfg_sel) begin
			reserve_base_q <= pwdata[BASE_W-1:0];
		end
	end

	// Controller and datapath.
	bia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.out_free  (out_free),
		.stat      (stat),
		.cmd       (cmd)
	);

	bia_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.op_in  (req.operation),
		.num_in (req.number),
		.base   (reserve_base_q),
		.stat   (stat),
		.result (result)
	);

	assign req.ready = cmd.idle;

	// Output register between the datapath and the response channel.
	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.result_number = rsp_q.result_number;
	assign rsp.is_valid      = rsp_q.is_valid;
	assign rsp.status        = rsp_q.status;

	// A bit is only marked busy when the evaluated word offered one.
	a_alloc_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_alloc |-> stat.hit)
		else $error("allocation write without a free bit");

	// A pending result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp_valid_q || rsp.ready))
		else $error("result register overwritten");

	// A pool-full answer carries no number.
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == ST_FULL) |-> (rsp_q.result_number == '0))
		else $error("pool full result with a number");

	// Map writes and result hand-off never coincide.
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_alloc, cmd.wr_free, cmd.load_out}))
		else $error("conflicting datapath commands");

endmodule

### test/tb_bitmap_id_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_id_allocator: self-checking testbench for the bitmap ID allocator
// Sends allocate, free, check and unused request words while both channels
// idle at random. A local model of the busy map, scan position and base
// register predicts every result word, and each result is compared with the
// oldest prediction. The base register is written and read back over APB
// between phases, the pool is driven to exhaustion once, and three random
// phases mix well-formed allocate/free pairs with noise.
// ----------------------------------------------------------------------------
module tb_bitmap_id_allocator;
	import bia_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 9;
	localparam int RANDOM_WORDS  = 1400;
	localparam int HELD_CAP      = 300;
	localparam int DRAIN_LIMIT   = 100000;
	localparam int SETTLE_CYCLES = 300;
	localparam longint TIMEOUT_NS = 400_000_000;

	// Register map: reserve_base is register 0; register 1 does not exist.
	localparam logic [CFG_ADDR_W-1:0] ADDR_BASE   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

	localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
	localparam logic [NUM_W-1:0]  NUM_MAX   = {NUM_W{1'b1}};
	localparam logic [BASE_W-1:0] BASE_MAX  = {BASE_W{1'b1}};

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	bia_req_if req_ch ();
	bia_rsp_if rsp_ch ();

	bitmap_id_allocator DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Model of the allocator state.
	logic             busy_bits [POOL_BITS];
	logic [POS_W-1:0] next_scan;
	logic [BASE_W-1:0] base_reg;

	rsp_t pending_results [$];
	int   held_slots [$];

	int errors;
	int send_idle_pct;
	int recv_idle_pct;
	int n_alloc, n_full, n_free, n_outside, n_check, n_unused, n_cfg_writes;

	// A programmed base of zero behaves as one.
	function automatic logic [31:0] effective_base();
		return (base_reg == '0) ? 32'd1 : 32'(base_reg);
	endfunction

	// Apply one request word to the model and return its result word.
	function automatic rsp_t predict_allocator(logic [OP_W-1:0] op, logic [NUM_W-1:0] num);
		rsp_t        r;
		logic [31:0] base;
		logic [31:0] n32;
		logic        found;
		int          k;
		base = effective_base();
		n32 = 32'(num);
		r = '0;
		found = 1'b0;
		case (op)
			OP_ALLOC: begin
				// Next-fit scan; a full pool walks all the way round.
				r.status = ST_FULL;
				for (k = 0; k < POOL_BITS && !found; k++) begin
					if (!busy_bits[next_scan]) begin
						busy_bits[next_scan] = 1'b1;
						r.result_number = NUM_W'(base + 32'(next_scan));
						r.status = ST_OK;
						found = 1'b1;
					end else begin
						next_scan = next_scan + 1'b1;
					end
				end
			end
			OP_FREE: begin
				if (n32 < base || (n32 - base) >= POOL_BITS) begin
					r.status = ST_OUTSIDE;
				end else begin
					busy_bits[n32 - base] = 1'b0;
				end
			end
			OP_CHECK: begin
				r.is_valid = (n32 >= base);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// Response side: stall at random while out of reset.
	always @(posedge clk) begin
		rsp_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Compare every accepted result word with the oldest prediction.
	always @(posedge clk) begin : result_checker
		rsp_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result word: result_number %0d is_valid %0d status %0d",
					rsp_ch.result_number, rsp_ch.is_valid, rsp_ch.status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.result_number !== want.result_number) begin
					$error("result_number: expected %0d, got %0d",
						want.result_number, rsp_ch.result_number);
					errors++;
				end
				if (rsp_ch.is_valid !== want.is_valid) begin
					$error("is_valid: expected %0d, got %0d", want.is_valid, rsp_ch.is_valid);
					errors++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					errors++;
				end
			end
		end
	end

	// Send one request word after a random gap and record its prediction.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [NUM_W-1:0] num);
		rsp_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.number    <= num;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		predicted = predict_allocator(op, num);
		pending_results.push_back(predicted);
		case (op)
			OP_ALLOC: begin
				n_alloc++;
				if (predicted.status == ST_FULL) begin
					n_full++;
				end else begin
					held_slots.push_back(int'(next_scan));
				end
			end
			OP_FREE: begin
				n_free++;
				if (predicted.status == ST_OUTSIDE) begin
					n_outside++;
				end
			end
			OP_CHECK: n_check++;
			default:  n_unused++;
		endcase
	endtask

	// Stop sending and wait until every predicted word has come back.
	task automatic wait_results_drained();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		n_cfg_writes++;
		if (addr == ADDR_BASE) begin
			base_reg = data[BASE_W-1:0];
		end
	endtask

	// APB read of the base register, compared with the model.
	task automatic check_base_register();
		logic [CFG_DATA_W-1:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_BASE;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== CFG_DATA_W'(base_reg)) begin
			$error("reserve_base: expected %0d, got %0d", base_reg, got);
			errors++;
		end
	endtask

	// Reset value, masking of wide writes, zero, and the missing register.
	task automatic test_register_access();
		check_base_register();
		write_register(ADDR_BASE, '0);
		check_base_register();
		write_register(ADDR_BASE, {CFG_DATA_W{1'b1}});
		check_base_register();
		write_register(ADDR_UNUSED, CFG_DATA_W'($urandom));
		check_base_register();
		write_register(ADDR_BASE, 32'd1);
		check_base_register();
	endtask

	// Field extremes, every operation and the boundary cases at three bases.
	task automatic test_directed_ops();
		logic [31:0] base;
		send_idle_pct = 0;
		recv_idle_pct = 0;

		// Base of one: allocate, checks at the edges, frees in and out of the pool.
		base = effective_base();
		send_request(OP_ALLOC, '0);
		send_request(OP_ALLOC, NUM_MAX);
		send_request(OP_CHECK, '0);
		send_request(OP_CHECK, NUM_W'(base));
		send_request(OP_CHECK, NUM_MAX);
		send_request(OP_FREE, NUM_W'(base));
		send_request(OP_FREE, NUM_W'(base));
		send_request(OP_FREE, '0);
		send_request(OP_FREE, NUM_W'(base + POOL_BITS - 1));
		send_request(OP_FREE, NUM_W'(base + POOL_BITS));
		send_request(OP_FREE, NUM_MAX);
		send_request(OP_UNUSED, NUM_MAX);
		send_request(OP_ALLOC, '0);
		wait_results_drained();

		// Programmed zero acts as one.
		write_register(ADDR_BASE, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_CHECK, '0);
		send_request(OP_CHECK, NUM_W'(1));
		send_request(OP_FREE, '0);
		send_request(OP_FREE, NUM_W'(1));
		wait_results_drained();

		// Largest base: allocate, checks around the base and frees at the top pool edge.
		write_register(ADDR_BASE, CFG_DATA_W'(BASE_MAX));
		base = effective_base();
		send_request(OP_ALLOC, '0);
		send_request(OP_CHECK, NUM_W'(base - 1));
		send_request(OP_CHECK, NUM_W'(base));
		send_request(OP_FREE, NUM_W'(base + POOL_BITS - 1));
		send_request(OP_FREE, NUM_W'(base + POOL_BITS));
		send_request(OP_UNUSED, '0);
		wait_results_drained();
	endtask

	// Fill the whole pool, hit the full case, reuse one slot, then free all.
	task automatic test_pool_exhaustion();
		logic [31:0] base;
		int          slot;
		int          i;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_register(ADDR_BASE, CFG_DATA_W'($urandom_range(2, 1 << 20)));
		check_base_register();
		base = effective_base();
		repeat (POOL_BITS) send_request(OP_ALLOC, NUM_W'($urandom));
		send_request(OP_ALLOC, '0);
		slot = $urandom_range(0, POOL_BITS - 1);
		send_request(OP_FREE, NUM_W'(base + slot));
		send_request(OP_ALLOC, '0);
		send_request(OP_ALLOC, '0);
		for (i = 0; i < POOL_BITS; i++) begin
			send_request(OP_FREE, NUM_W'(base + i));
		end
		held_slots.delete();
		wait_results_drained();
	endtask

	// One random word: mostly allocate/free pairs, the rest checks and noise.
	task automatic send_random_request();
		logic [31:0]      base;
		logic [OP_W-1:0]  op;
		logic [NUM_W-1:0] num;
		int               pick;
		int               idx;
		base = effective_base();
		pick = $urandom_range(99);
		num = NUM_W'($urandom);
		if (pick < 40 && held_slots.size() >= HELD_CAP) begin
			pick = 50;
		end
		if (pick >= 40 && pick < 70 && held_slots.size() == 0) begin
			pick = 0;
		end
		if (pick < 40) begin
			op = OP_ALLOC;
		end else if (pick < 70) begin
			// Release a number that is currently handed out.
			op = OP_FREE;
			idx = $urandom_range(0, held_slots.size() - 1);
			num = NUM_W'(base + held_slots[idx]);
			held_slots.delete(idx);
		end else if (pick < 80) begin
			// Free near and across both pool edges.
			op = OP_FREE;
			if ($urandom_range(1)) begin
				num = NUM_W'(base + $urandom_range(0, 16) - 8);
			end else begin
				num = NUM_W'(base + POOL_BITS + $urandom_range(0, 16) - 8);
			end
		end else if (pick < 93) begin
			op = OP_CHECK;
			if ($urandom_range(1)) begin
				num = NUM_W'(base + $urandom_range(0, 4) - 2);
			end
		end else if (pick < 97) begin
			op = OP_FREE;
		end else begin
			op = OP_UNUSED;
		end
		send_request(op, num);
	endtask

	// Three phases with different idling and base settings.
	task automatic test_random_traffic();
		int phase;
		int i;
		int words;
		words = RANDOM_WORDS / 3;
		for (phase = 0; phase < 3; phase++) begin
			wait_results_drained();
			case (phase)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 78;
					write_register(ADDR_BASE, CFG_DATA_W'($urandom_range(2, BASE_MAX)));
				end
				1: begin
					send_idle_pct = 78;
					recv_idle_pct = 19;
					write_register(ADDR_BASE, CFG_DATA_W'(BASE_MAX));
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					write_register(ADDR_BASE, '0);
				end
			endcase
			check_base_register();
			for (i = 0; i < words; i++) begin
				// Now and then hold off until every result is back.
				if ((phase == 0 && i == words / 2) || $urandom_range(199) == 0) begin
					wait_results_drained();
				end
				send_random_request();
			end
		end
	endtask

	// Wait for the last results, allow for stray words, and report.
	task automatic finish_run();
		int waited;
		req_ch.valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected result words never arrived", pending_results.size());
			errors += pending_results.size();
		end
		$display("Covered %0d allocations (%0d with the pool full), %0d frees (%0d outside).",
			n_alloc, n_full, n_free, n_outside);
		$display("Also %0d checks, %0d unused operations and %0d register writes.",
			n_check, n_unused, n_cfg_writes);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	endtask

	// Main sequence.
	initial begin
		arst_n           <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.operation <= '0;
		req_ch.number    <= '0;
		foreach (busy_bits[i]) busy_bits[i] = 1'b0;
		next_scan = '0;
		base_reg = BASE_RESET;
		errors = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		n_alloc = 0;
		n_full = 0;
		n_free = 0;
		n_outside = 0;
		n_check = 0;
		n_unused = 0;
		n_cfg_writes = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_directed_ops();
		test_pool_exhaustion();
		test_random_traffic();
		finish_run();
	end

	// Watchdog for a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
src/bia_pkg.sv
src/bia_if.sv
src/bia_ctrl.sv
src/bia_dpath.sv
src/bitmap_id_allocator.sv
test/tb_bitmap_id_allocator.sv
